/* src/point_set_covariance_3d_core_assert.svh */
// Assertion macros shared by the covariance core modules.
// Expects signals clk and rst in the including scope.
`ifndef POINT_SET_COVARIANCE_3D_CORE_ASSERT_SVH
`define POINT_SET_COVARIANCE_3D_CORE_ASSERT_SVH

// same-cycle implication
`define PSC3D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSC3D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/psc3d_pkg.sv */
// Shared types and constants for the 3D point set covariance core.
// No dependencies.
`timescale 1ns / 1ps

package psc3d_pkg;

  localparam int IN_W         = 24;
  localparam int ENTRY_W      = 56;
  localparam int COUNT_OUT_W  = 11;
  localparam int CFG_W        = 11;
  localparam int FRAC_BITS    = 8;
  localparam int MIN_SET_SIZE = 2;
  localparam logic [CFG_W-1:0] MIN_POINTS_RESET = 11'd3;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_FEW  = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    E_XX = 3'd0,
    E_XY = 3'd1,
    E_XZ = 3'd2,
    E_YY = 3'd3,
    E_YZ = 3'd4,
    E_ZZ = 3'd5
  } entry_t;

  typedef struct packed {
    logic   accept;
    logic   check;
    logic   mul_load;
    logic   mul_cross;
    logic   mul_step;
    logic   take_term;
    logic   sub_term;
    logic   div_load;
    logic   div_step;
    logic   store;
    logic   emit;
    entry_t entry;
  } dp_cmd_t;

  typedef struct packed {
    logic ok;
  } dp_stat_t;

endpackage

/* src/point_set_covariance_3d_core.sv */
// Top level of the 3D point set covariance core.
// Depends on psc3d_pkg, psc3d_ctrl and psc3d_dp.
//
//  channel   handshake           payload
//  -------   -----------------   ------------------------------------------
//  point     start / busy        coord_x, coord_y, coord_z, last_point
//  result    done (1 cycle)      cov_xx..cov_zz, point_count, status
//  config    cfg_write           cfg_data (min_points)
//
// A point is taken every cycle in which start is high and busy is low.
// After the last point busy stays high while the shift-add multiplier and the
// one-bit-per-cycle divider run for each of the six entries; when the status
// is not ok the entries are skipped. done pulses in the same cycle that busy
// falls.
// rst is synchronous and returns min_points to 3 and clears all sums.
// The result cannot be stalled; it is valid only while done is high.
`timescale 1ns / 1ps

module point_set_covariance_3d_core #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [psc3d_pkg::IN_W-1:0]    coord_x,
  input  logic signed [psc3d_pkg::IN_W-1:0]    coord_y,
  input  logic signed [psc3d_pkg::IN_W-1:0]    coord_z,
  input  logic                                 last_point,
  input  logic                                 cfg_write,
  input  logic [psc3d_pkg::CFG_W-1:0]          cfg_data,
  output logic                                 done,
  output logic signed [psc3d_pkg::ENTRY_W-1:0] cov_xx,
  output logic signed [psc3d_pkg::ENTRY_W-1:0] cov_xy,
  output logic signed [psc3d_pkg::ENTRY_W-1:0] cov_xz,
  output logic signed [psc3d_pkg::ENTRY_W-1:0] cov_yy,
  output logic signed [psc3d_pkg::ENTRY_W-1:0] cov_yz,
  output logic signed [psc3d_pkg::ENTRY_W-1:0] cov_zz,
  output logic [psc3d_pkg::COUNT_OUT_W-1:0]    point_count,
  output psc3d_pkg::status_t                   status
);
  import psc3d_pkg::*;

  localparam int LOGN = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int SW   = COORD_BITS + LOGN + 1;
  localparam int PW   = 2 * COORD_BITS + LOGN;
  localparam int NUMW = (2 * SW + 1 > CW + PW + 2) ? 2 * SW + 1 : CW + PW + 2;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  psc3d_ctrl #(
    .MUL1_STEPS (CW),
    .MUL2_STEPS (SW),
    .DIV_STEPS  (NUMW + FRAC_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .last_point (last_point),
    .busy       (busy),
    .done       (done),
    .cmd        (cmd),
    .stat       (stat)
  );

  psc3d_dp #(
    .MAX_POINTS (MAX_POINTS),
    .CB         (COORD_BITS),
    .CW         (CW),
    .SW         (SW),
    .PW         (PW),
    .NUMW       (NUMW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .cov_xx      (cov_xx),
    .cov_xy      (cov_xy),
    .cov_xz      (cov_xz),
    .cov_yy      (cov_yy),
    .cov_yz      (cov_yz),
    .cov_zz      (cov_zz),
    .point_count (point_count),
    .status      (status)
  );

endmodule

/* src/psc3d_dp.sv */
// Datapath: point pipeline, running sums, shift-add multiplier,
// restoring divider and result registers. Depends on psc3d_pkg.
`timescale 1ns / 1ps
`include "point_set_covariance_3d_core_assert.svh"

module psc3d_dp #(
  parameter int MAX_POINTS = 1024,
  parameter int CB         = 24,
  parameter int CW         = 11,
  parameter int SW         = 35,
  parameter int PW         = 58,
  parameter int NUMW       = 71
) (
  input  logic                              clk,
  input  logic                              rst,
  input  psc3d_pkg::dp_cmd_t                cmd,
  output psc3d_pkg::dp_stat_t               stat,
  input  logic signed [psc3d_pkg::IN_W-1:0] coord_x,
  input  logic signed [psc3d_pkg::IN_W-1:0] coord_y,
  input  logic signed [psc3d_pkg::IN_W-1:0] coord_z,
  input  logic                              cfg_write,
  input  logic [psc3d_pkg::CFG_W-1:0]       cfg_data,
  output logic signed [psc3d_pkg::ENTRY_W-1:0] cov_xx,
  output logic signed [psc3d_pkg::ENTRY_W-1:0] cov_xy,
  output logic signed [psc3d_pkg::ENTRY_W-1:0] cov_xz,
  output logic signed [psc3d_pkg::ENTRY_W-1:0] cov_yy,
  output logic signed [psc3d_pkg::ENTRY_W-1:0] cov_yz,
  output logic signed [psc3d_pkg::ENTRY_W-1:0] cov_zz,
  output logic [psc3d_pkg::COUNT_OUT_W-1:0]    point_count,
  output psc3d_pkg::status_t                   status
);
  import psc3d_pkg::*;

  localparam int DW   = NUMW + FRAC_BITS;
  localparam int DDW  = 2 * CW;
  localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;

  logic [CFG_W-1:0] min_points;
  logic [CW-1:0]    count;
  logic             overflow;

  logic                 s1_valid, s2_valid;
  logic signed [CB-1:0] cx, cy, cz;
  logic signed [2*CB-1:0] pxx, pxy, pxz, pyy, pyz, pzz;

  logic signed [SW-1:0] sx, sy, sz;
  logic signed [PW-1:0] sxx, sxy, sxz, syy, syz, szz;

  logic [NUMW-1:0]        ma, acc;
  logic [SW-1:0]          mb;
  logic                   mneg;
  logic signed [NUMW-1:0] num;

  logic [DW-1:0]      dvd;
  logic [DDW-1:0]     rem, d;
  logic [ENTRY_W-1:0] q;
  logic               dneg;

  logic                 keep;
  logic signed [PW-1:0] sab;
  logic signed [SW-1:0] sa, sb;
  logic [PW-1:0]        sab_mag;
  logic [SW-1:0]        sa_mag, sb_mag;
  logic [NUMW-1:0]      num_mag;
  logic [DDW:0]         trial;
  logic                 ge;
  logic [DDW-1:0]       d_full;
  logic [CMPW-1:0]      need;
  logic                 too_few;
  logic [ENTRY_W-1:0]   entry_val;

  assign keep = count < CW'(MAX_POINTS);

  always_comb begin
    unique case (cmd.entry)
      E_XX: begin sab = sxx; sa = sx; sb = sx; end
      E_XY: begin sab = sxy; sa = sx; sb = sy; end
      E_XZ: begin sab = sxz; sa = sx; sb = sz; end
      E_YY: begin sab = syy; sa = sy; sb = sy; end
      E_YZ: begin sab = syz; sa = sy; sb = sz; end
      E_ZZ: begin sab = szz; sa = sz; sb = sz; end
      default: begin sab = '0; sa = '0; sb = '0; end
    endcase
  end

  assign sab_mag = sab[PW-1] ? PW'(-sab) : PW'(sab);
  assign sa_mag  = sa[SW-1] ? SW'(-sa) : SW'(sa);
  assign sb_mag  = sb[SW-1] ? SW'(-sb) : SW'(sb);
  assign num_mag = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);

  assign trial = {rem, dvd[DW-1]};
  assign ge    = trial >= {1'b0, d};

  assign d_full  = DDW'(count) * DDW'(count - CW'(1));
  assign need    = (min_points < CFG_W'(MIN_SET_SIZE)) ? CMPW'(MIN_SET_SIZE)
                                                       : CMPW'(min_points);
  assign too_few = CMPW'(count) < need;
  assign stat.ok = !overflow && !too_few;

  assign entry_val = dneg ? ('0 - q) : q;

  // control and running state
  always_ff @(posedge clk) begin
    if (rst) begin
      min_points <= MIN_POINTS_RESET;
      count      <= '0;
      overflow   <= 1'b0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      sx  <= '0; sy  <= '0; sz  <= '0;
      sxx <= '0; sxy <= '0; sxz <= '0;
      syy <= '0; syz <= '0; szz <= '0;
    end else begin
      if (cfg_write) begin
        min_points <= cfg_data;
      end
      s1_valid <= cmd.accept && keep;
      s2_valid <= s1_valid;
      priority if (cmd.emit) begin
        count    <= '0;
        overflow <= 1'b0;
        sx  <= '0; sy  <= '0; sz  <= '0;
        sxx <= '0; sxy <= '0; sxz <= '0;
        syy <= '0; syz <= '0; szz <= '0;
      end else begin
        if (cmd.accept) begin
          if (keep) begin
            count <= count + CW'(1);
          end else begin
            overflow <= 1'b1;
          end
        end
        if (s1_valid) begin
          sx <= sx + SW'(cx);
          sy <= sy + SW'(cy);
          sz <= sz + SW'(cz);
        end
        if (s2_valid) begin
          sxx <= sxx + PW'(pxx);
          sxy <= sxy + PW'(pxy);
          sxz <= sxz + PW'(pxz);
          syy <= syy + PW'(pyy);
          syz <= syz + PW'(pyz);
          szz <= szz + PW'(pzz);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cx <= coord_x[CB-1:0];
      cy <= coord_y[CB-1:0];
      cz <= coord_z[CB-1:0];
    end
    pxx <= cx * cx;
    pxy <= cx * cy;
    pxz <= cx * cz;
    pyy <= cy * cy;
    pyz <= cy * cz;
    pzz <= cz * cz;

    if (cmd.check) begin
      d           <= d_full;
      point_count <= COUNT_OUT_W'(count);
      status      <= overflow ? STATUS_OVERFLOW : (too_few ? STATUS_TOO_FEW : STATUS_OK);
      cov_xx <= '0; cov_xy <= '0; cov_xz <= '0;
      cov_yy <= '0; cov_yz <= '0; cov_zz <= '0;
    end

    if (cmd.mul_load) begin
      acc <= '0;
      if (cmd.mul_cross) begin
        ma   <= NUMW'(sa_mag);
        mb   <= sb_mag;
        mneg <= sa[SW-1] ^ sb[SW-1];
      end else begin
        ma   <= NUMW'(sab_mag);
        mb   <= SW'(count);
        mneg <= sab[PW-1];
      end
    end else if (cmd.mul_step) begin
      if (mb[0]) begin
        acc <= acc + ma;
      end
      ma <= ma << 1;
      mb <= mb >> 1;
    end

    if (cmd.take_term) begin
      num <= mneg ? ('0 - acc) : acc;
    end else if (cmd.sub_term) begin
      num <= mneg ? (num + acc) : (num - acc);
    end

    if (cmd.div_load) begin
      dneg <= num[NUMW-1];
      dvd  <= {num_mag, {FRAC_BITS{1'b0}}};
      rem  <= '0;
      q    <= '0;
    end else if (cmd.div_step) begin
      rem <= ge ? DDW'(trial - {1'b0, d}) : DDW'(trial);
      q   <= {q[ENTRY_W-2:0], ge};
      dvd <= dvd << 1;
    end

    if (cmd.store) begin
      unique case (cmd.entry)
        E_XX: cov_xx <= entry_val;
        E_XY: cov_xy <= entry_val;
        E_XZ: cov_xz <= entry_val;
        E_YY: cov_yy <= entry_val;
        E_YZ: cov_yz <= entry_val;
        E_ZZ: cov_zz <= entry_val;
        default: ;
      endcase
    end
  end

  `PSC3D_ASSERT_NOW(a_rem_below_div, cmd.div_step, rem < d, "divider remainder not below divisor")
  `PSC3D_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(MAX_POINTS), "point count above limit")
  `PSC3D_ASSERT_NEXT(a_emit_clears, cmd.emit, count == '0 && !overflow, "set not cleared after emit")

endmodule

/* src/psc3d_ctrl.sv */
// Controller: accepts points, sequences the per-entry multiply and divide
// steps, and raises the result strobe. Depends on psc3d_pkg.
`timescale 1ns / 1ps
`include "point_set_covariance_3d_core_assert.svh"

module psc3d_ctrl #(
  parameter int MUL1_STEPS = 11,
  parameter int MUL2_STEPS = 35,
  parameter int DIV_STEPS  = 79
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 last_point,
  output logic                 busy,
  output logic                 done,
  output psc3d_pkg::dp_cmd_t   cmd,
  input  psc3d_pkg::dp_stat_t  stat
);
  import psc3d_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    S_IDLE, S_DRAIN1, S_DRAIN2, S_CHECK,
    S_MUL1_LD, S_MUL1, S_TERM1,
    S_MUL2_LD, S_MUL2, S_TERM2,
    S_DIV_LD, S_DIV, S_STORE, S_EMIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  entry_t           entry;

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      entry <= E_XX;
      done  <= 1'b0;
    end else begin
      done <= state == S_EMIT;
      unique case (state)
        S_IDLE: begin
          if (start && last_point) begin
            state <= S_DRAIN1;
          end
        end
        S_DRAIN1: state <= S_DRAIN2;
        S_DRAIN2: state <= S_CHECK;
        S_CHECK: begin
          entry <= E_XX;
          state <= stat.ok ? S_MUL1_LD : S_EMIT;
        end
        S_MUL1_LD: begin
          cnt   <= CNT_W'(MUL1_STEPS - 1);
          state <= S_MUL1;
        end
        S_MUL1: begin
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= S_TERM1;
          end
        end
        S_TERM1: state <= S_MUL2_LD;
        S_MUL2_LD: begin
          cnt   <= CNT_W'(MUL2_STEPS - 1);
          state <= S_MUL2;
        end
        S_MUL2: begin
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= S_TERM2;
          end
        end
        S_TERM2: state <= S_DIV_LD;
        S_DIV_LD: begin
          cnt   <= CNT_W'(DIV_STEPS - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          if (entry == E_ZZ) begin
            state <= S_EMIT;
          end else begin
            entry <= entry_t'(entry + 3'd1);
            state <= S_MUL1_LD;
          end
        end
        S_EMIT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.entry     = entry;
    cmd.accept    = (state == S_IDLE) && start;
    cmd.check     = state == S_CHECK;
    cmd.mul_load  = (state == S_MUL1_LD) || (state == S_MUL2_LD);
    cmd.mul_cross = state == S_MUL2_LD;
    cmd.mul_step  = (state == S_MUL1) || (state == S_MUL2);
    cmd.take_term = state == S_TERM1;
    cmd.sub_term  = state == S_TERM2;
    cmd.div_load  = state == S_DIV_LD;
    cmd.div_step  = state == S_DIV;
    cmd.store     = state == S_STORE;
    cmd.emit      = state == S_EMIT;
  end

  `PSC3D_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
  `PSC3D_ASSERT_NEXT(a_last_busy, start && !busy && last_point, busy, "last item did not start finish")
  `PSC3D_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")

endmodule

/* test/psc3d_cov_checker.sv */
`timescale 1ns / 1ps
// Checker for the 3D point set covariance core: tracks min_points writes, predicts
// the result of every point set and compares each result field by field.
// Depends on psc3d_pkg.

module psc3d_cov_checker #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic signed [psc3d_pkg::IN_W-1:0]    coord_x,
  input  logic signed [psc3d_pkg::IN_W-1:0]    coord_y,
  input  logic signed [psc3d_pkg::IN_W-1:0]    coord_z,
  input  logic                                 last_point,
  input  logic                                 cfg_write,
  input  logic [psc3d_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                 done,
  input  logic signed [psc3d_pkg::ENTRY_W-1:0] cov_xx,
  input  logic signed [psc3d_pkg::ENTRY_W-1:0] cov_xy,
  input  logic signed [psc3d_pkg::ENTRY_W-1:0] cov_xz,
  input  logic signed [psc3d_pkg::ENTRY_W-1:0] cov_yy,
  input  logic signed [psc3d_pkg::ENTRY_W-1:0] cov_yz,
  input  logic signed [psc3d_pkg::ENTRY_W-1:0] cov_zz,
  input  logic [psc3d_pkg::COUNT_OUT_W-1:0]    point_count,
  input  psc3d_pkg::status_t                   status,
  output int                                   errors,
  output int                                   pending
);
  import psc3d_pkg::*;

  localparam int AX_X = 0;
  localparam int AX_Y = 1;
  localparam int AX_Z = 2;
  localparam int N_AXES = 3;
  localparam int N_ENTRIES = 6;

  typedef struct packed {
    logic [N_ENTRIES-1:0][ENTRY_W-1:0] cov;
    logic [COUNT_OUT_W-1:0]            count;
    status_t                           stat;
  } set_result_t;

  // exact sums, far wider than the block needs
  logic signed [127:0] coord_sum [N_AXES];
  logic signed [127:0] product_sum [N_ENTRIES];
  int unsigned         held;
  bit                  dropped;
  logic [CFG_W-1:0]    min_set;
  set_result_t         result_q [$];

  initial begin
    errors = 0;
    pending = 0;
  end

  function automatic void entry_axes(entry_t e, output int a, output int b);
    case (e)
      E_XX: begin a = AX_X; b = AX_X; end
      E_XY: begin a = AX_X; b = AX_Y; end
      E_XZ: begin a = AX_X; b = AX_Z; end
      E_YY: begin a = AX_Y; b = AX_Y; end
      E_YZ: begin a = AX_Y; b = AX_Z; end
      default: begin a = AX_Z; b = AX_Z; end
    endcase
  endfunction

  function automatic void start_new_set();
    for (int i = 0; i < N_AXES; i++) coord_sum[i] = '0;
    for (int k = 0; k < N_ENTRIES; k++) product_sum[k] = '0;
    held = 0;
    dropped = 1'b0;
  endfunction

  // (n*Sab - Sa*Sb) * 256 / (n*(n-1)), truncated toward zero
  function automatic logic [ENTRY_W-1:0] entry_value(entry_t e);
    logic signed [127:0] n, num, q;
    int a, b;
    entry_axes(e, a, b);
    n = held;
    num = (n * product_sum[e] - coord_sum[a] * coord_sum[b]) * 256;
    q = num / (n * (n - 1));
    return q[ENTRY_W-1:0];
  endfunction

  function automatic void take_point();
    logic signed [127:0] c [N_AXES];
    set_result_t res;
    int unsigned need;
    int a, b;
    if (held < MAX_POINTS) begin
      c[AX_X] = coord_x;
      c[AX_Y] = coord_y;
      c[AX_Z] = coord_z;
      for (int i = 0; i < N_AXES; i++) coord_sum[i] += c[i];
      for (int k = 0; k < N_ENTRIES; k++) begin
        entry_axes(entry_t'(k), a, b);
        product_sum[k] += c[a] * c[b];
      end
      held++;
    end else begin
      dropped = 1'b1;
    end
    if (last_point) begin
      need = (min_set < MIN_SET_SIZE) ? MIN_SET_SIZE : min_set;
      if (dropped) res.stat = STATUS_OVERFLOW;
      else if (held < need) res.stat = STATUS_TOO_FEW;
      else res.stat = STATUS_OK;
      for (int k = 0; k < N_ENTRIES; k++)
        res.cov[k] = (res.stat == STATUS_OK) ? entry_value(entry_t'(k)) : '0;
      res.count = held[COUNT_OUT_W-1:0];
      result_q.push_back(res);
      start_new_set();
    end
  endfunction

  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    set_result_t want;
    if (rst) begin
      start_new_set();
      min_set = MIN_POINTS_RESET;
      result_q.delete();
    end else begin
      if (done) begin
        if (result_q.size() == 0) begin
          $display("%0t: result with no set pending: expected none, got count %0d status %0d",
                   $time, point_count, status);
          errors++;
        end else begin
          want = result_q.pop_front();
          check_field("cov_xx", $signed(want.cov[E_XX]), cov_xx);
          check_field("cov_xy", $signed(want.cov[E_XY]), cov_xy);
          check_field("cov_xz", $signed(want.cov[E_XZ]), cov_xz);
          check_field("cov_yy", $signed(want.cov[E_YY]), cov_yy);
          check_field("cov_yz", $signed(want.cov[E_YZ]), cov_yz);
          check_field("cov_zz", $signed(want.cov[E_ZZ]), cov_zz);
          check_field("point_count", want.count, point_count);
          check_field("status", want.stat, status);
        end
      end
      if (cfg_write) min_set = cfg_data;
      if (start && !busy) take_point();
    end
    pending = result_q.size();
  end

endmodule

/* test/tb_point_set_covariance_3d_core.sv */
`timescale 1ns / 1ps
// Testbench top for point_set_covariance_3d_core, drives point sets and min_points
// writes, gives the verdict. Depends on the core, psc3d_pkg and psc3d_cov_checker.

module tb_point_set_covariance_3d_core;
  import psc3d_pkg::*;

  localparam int MAX_POINTS = 1024;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_CYCLES = 10;
  localparam int DRAIN_CYCLES = 800;
  localparam logic signed [IN_W-1:0] COORD_MAX = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic signed [IN_W-1:0] COORD_MIN = {1'b1, {(IN_W-1){1'b0}}};

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [IN_W-1:0]    coord_x = '0;
  logic signed [IN_W-1:0]    coord_y = '0;
  logic signed [IN_W-1:0]    coord_z = '0;
  logic                      last_point = 1'b0;
  logic                      cfg_write = 1'b0;
  logic [CFG_W-1:0]          cfg_data = '0;
  logic                      done;
  logic signed [ENTRY_W-1:0] cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz;
  logic [COUNT_OUT_W-1:0]    point_count;
  status_t                   status;
  int                        errors;
  int                        pending;
  int                        cycles = 0;
  int                        gap_max = 0;
  int                        burst_left = 0;

  always #1 clk = ~clk;

  point_set_covariance_3d_core #(.MAX_POINTS(MAX_POINTS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z), .last_point(last_point),
    .cfg_write(cfg_write), .cfg_data(cfg_data), .done(done),
    .cov_xx(cov_xx), .cov_xy(cov_xy), .cov_xz(cov_xz),
    .cov_yy(cov_yy), .cov_yz(cov_yz), .cov_zz(cov_zz),
    .point_count(point_count), .status(status)
  );

  psc3d_cov_checker #(.MAX_POINTS(MAX_POINTS)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z), .last_point(last_point),
    .cfg_write(cfg_write), .cfg_data(cfg_data), .done(done),
    .cov_xx(cov_xx), .cov_xy(cov_xy), .cov_xz(cov_xz),
    .cov_yy(cov_yy), .cov_yz(cov_yz), .cov_zz(cov_zz),
    .point_count(point_count), .status(status),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic signed [IN_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return '0;
      3: return '1;
      4: return IN_W'($signed($urandom_range(0, 64)) - 32);
      default: return IN_W'($urandom);
    endcase
  endfunction

  // bursts of random length, then a random gap with start low
  task automatic pace();
    int gap;
    if (gap_max == 0) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 15);
    gap = $urandom_range(1, gap_max);
    @(negedge clk);
    start <= 1'b0;
    coord_x <= IN_W'($urandom);
    coord_y <= IN_W'($urandom);
    coord_z <= IN_W'($urandom);
    last_point <= 1'($urandom);
    repeat (gap - 1) @(negedge clk);
  endtask

  task automatic send_point(input logic signed [IN_W-1:0] x, y, z, input logic last);
    @(negedge clk);
    start <= 1'b1;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    last_point <= last;
    do @(posedge clk); while (busy);
    pace();
  endtask

  task automatic send_set(int len);
    logic signed [IN_W-1:0] x, y, z;
    bit tied;
    tied = ($urandom_range(0, 5) == 0);
    for (int i = 0; i < len; i++) begin
      x = rand_coord();
      y = rand_coord();
      z = rand_coord();
      if (tied) begin
        y = x;
        z = -x;
      end
      send_point(x, y, z, i == len - 1);
    end
  endtask

  task automatic random_sets(int n_items);
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      send_set(len);
      sent += len;
    end
  endtask

  task automatic write_min_points(logic [CFG_W-1:0] value);
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // min_points at reset value
    send_point(COORD_MAX, COORD_MIN, '0, 1'b1);
    send_point(24'sd1, 24'sd2, 24'sd3, 1'b0);
    send_point(-24'sd1, -24'sd2, -24'sd3, 1'b1);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    send_point(COORD_MAX, COORD_MIN, '0, 1'b1);
    repeat (3) send_point(24'sh555555, 24'shAAAAAA, '1, 1'b0);
    send_point(24'sh555555, 24'shAAAAAA, '1, 1'b1);
    send_point(24'shAAAAAA, 24'sh555555, '0, 1'b0);
    send_point(COORD_MIN, COORD_MAX, 24'sd1, 1'b0);
    send_point('1, '0, COORD_MIN, 1'b1);

    gap_max = 6;
    write_min_points(11'd0);
    random_sets(70);

    gap_max = 0;
    write_min_points(11'd1);
    send_point(COORD_MIN, COORD_MAX, 24'sd7, 1'b0);
    send_point(COORD_MAX, COORD_MIN, -24'sd7, 1'b1);
    random_sets(60);

    // min_points above MAX_POINTS: every set is too few
    gap_max = 3;
    write_min_points(11'd2047);
    random_sets(40);

    gap_max = 0;
    write_min_points(11'd1024);
    random_sets(30);

    gap_max = 8;
    write_min_points(CFG_W'($urandom_range(4, 12)));
    random_sets(130);

    gap_max = 4;
    write_min_points(11'd2);
    random_sets(110);

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
